[hdl/cfct_pkg.sv]
// shared types and constants for the client flow counter table
// used by cfct_front, cfct_back and client_flow_counter_table_core
package cfct_pkg;

  localparam int BUCKETS    = 1024;
  localparam int WAYS       = 4;
  localparam int COUNT_BITS = 32;

  localparam int BKT_BITS = $clog2(BUCKETS);
  localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam int FQ_DEPTH    = 4;
  localparam int FQ_PTR_BITS = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_BITS = $clog2(FQ_DEPTH + 1);

  localparam int OQ_DEPTH    = 2;
  localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  typedef enum logic [1:0] {
    ST_COUNTED = 2'd0,
    ST_REMOVED = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_EXEC
  } back_state_t;

  typedef struct packed {
    logic                op;
    logic [31:0]         ip;
    logic [15:0]         port;
    logic [BKT_BITS-1:0] bucket;
  } q_item_t;

  typedef struct packed {
    logic                  vld;
    logic [31:0]           addr;
    logic [15:0]           port;
    logic [COUNT_BITS-1:0] cnt;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic [31:0] count;
    status_t     status;
  } res_t;

endpackage

[hdl/client_flow_counter_table_core.sv]
// top level of the client flow counter table
// depends on cfct_pkg, cfct_front and cfct_back
//
// input queue: in_push / in_full carry one request (in_op, in_src_ip,
//   in_src_port); in_op low counts a packet, high closes the client
// result queue: while out_empty is low the oldest result is on out_count
//   and out_status; out_pop takes it
// status: counted, removed, close of unknown client, bucket full
// request path: request queue, row read in the idle state, then the
//   read-modify-write and result push in the exec state
// the engine takes a new request only after the read-modify-write of the
//   last one, as both use the single-port bucket row memory
// a four-deep request queue and a two-deep result queue part the sides:
//   when out_pop stays low the engine stops once the result queue is full,
//   requests pile up in the request queue and in_full rises when it fills
// reset: synchronous on rst_n; afterwards a clearing pass writes every
//   bucket row, with in_full held high until it ends
module client_flow_counter_table_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_op,
  input  logic [31:0] in_src_ip,
  input  logic [15:0] in_src_port,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_count,
  output logic [1:0]  out_status
);

  cfct_pkg::q_item_t q_item;
  logic              q_valid;
  logic              q_pop;
  logic              clearing;

  cfct_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_op       (in_op),
    .in_src_ip   (in_src_ip),
    .in_src_port (in_src_port),
    .clearing    (clearing),
    .q_item      (q_item),
    .q_valid     (q_valid),
    .q_pop       (q_pop)
  );

  cfct_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_count  (out_count),
    .out_status (out_status)
  );

endmodule

[hdl/cfct_front.sv]
// front end: accepts requests, computes the bucket and queues them for the back end
// depends on cfct_pkg
module cfct_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_op,
  input  logic [31:0]        in_src_ip,
  input  logic [15:0]        in_src_port,
  input  logic               clearing,
  output cfct_pkg::q_item_t  q_item,
  output logic               q_valid,
  input  logic               q_pop
);

  cfct_pkg::q_item_t                 fq_r [cfct_pkg::FQ_DEPTH];
  logic [cfct_pkg::FQ_PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [cfct_pkg::FQ_PTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [cfct_pkg::FQ_CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                              accept;
  logic                              do_pop;
  cfct_pkg::q_item_t                 new_item;

  assign in_full = clearing || (cnt_r == cfct_pkg::FQ_CNT_BITS'(cfct_pkg::FQ_DEPTH));
  assign accept  = in_push && !in_full;
  assign q_valid = (cnt_r != '0);
  assign do_pop  = q_pop && q_valid;
  assign q_item  = fq_r[rd_ptr_r];

  // bucket is the low bits of address xor port
  always_comb begin
    new_item.op     = in_op;
    new_item.ip     = in_src_ip;
    new_item.port   = in_src_port;
    new_item.bucket = cfct_pkg::BKT_BITS'(in_src_ip ^ {16'b0, in_src_port});
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (accept) begin
      wr_ptr_nxt = (wr_ptr_r == cfct_pkg::FQ_PTR_BITS'(cfct_pkg::FQ_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == cfct_pkg::FQ_PTR_BITS'(cfct_pkg::FQ_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (accept && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!accept && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fq_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

[hdl/cfct_back.sv]
// back end: bucket row memory, read-modify-write engine, reset clearing pass
// and result queue; depends on cfct_pkg
module cfct_back (
  input  logic               clk,
  input  logic               rst_n,
  input  cfct_pkg::q_item_t  q_item,
  input  logic               q_valid,
  output logic               q_pop,
  output logic               clearing,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [31:0]        out_count,
  output logic [1:0]         out_status
);

  cfct_pkg::row_t                   mem [cfct_pkg::BUCKETS];
  cfct_pkg::row_t                   rd_row_r;
  cfct_pkg::q_item_t                item_r;
  cfct_pkg::back_state_t            state_r, state_nxt;
  logic [cfct_pkg::BKT_BITS-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic                             clr_last;

  cfct_pkg::res_t                   oq_r [cfct_pkg::OQ_DEPTH];
  logic [cfct_pkg::OQ_PTR_BITS-1:0] oq_wr_r, oq_wr_nxt;
  logic [cfct_pkg::OQ_PTR_BITS-1:0] oq_rd_r, oq_rd_nxt;
  logic [cfct_pkg::OQ_CNT_BITS-1:0] oq_cnt_r, oq_cnt_nxt;
  logic                             oq_room;
  logic                             oq_push;
  logic                             oq_pop;

  logic                             mem_we;
  logic [cfct_pkg::BKT_BITS-1:0]    mem_waddr;
  cfct_pkg::row_t                   mem_wdata;

  logic                             hit;
  logic [cfct_pkg::WAY_BITS-1:0]    hit_way;
  logic                             free;
  logic [cfct_pkg::WAY_BITS-1:0]    free_way;
  logic [cfct_pkg::WAY_BITS-1:0]    sel_way;
  logic [cfct_pkg::COUNT_BITS-1:0]  cur_cnt;
  logic [cfct_pkg::COUNT_BITS-1:0]  new_cnt;
  cfct_pkg::row_t                   upd_row;
  cfct_pkg::res_t                   res;

  assign clr_last = (clr_cnt_r == cfct_pkg::BKT_BITS'(cfct_pkg::BUCKETS - 1));
  assign oq_room  = (oq_cnt_r < cfct_pkg::OQ_CNT_BITS'(cfct_pkg::OQ_DEPTH));

  // next state
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      cfct_pkg::BS_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_last) begin
          state_nxt = cfct_pkg::BS_IDLE;
        end
      end
      cfct_pkg::BS_IDLE: begin
        if (q_valid && oq_room) begin
          state_nxt = cfct_pkg::BS_EXEC;
        end
      end
      cfct_pkg::BS_EXEC: begin
        state_nxt = cfct_pkg::BS_IDLE;
      end
      default: begin
        state_nxt = cfct_pkg::BS_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    clearing  = 1'b0;
    q_pop     = 1'b0;
    oq_push   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = item_r.bucket;
    mem_wdata = upd_row;
    case (state_r)
      cfct_pkg::BS_CLEAR: begin
        clearing  = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      cfct_pkg::BS_IDLE: begin
        q_pop = q_valid && oq_room;
      end
      cfct_pkg::BS_EXEC: begin
        mem_we  = 1'b1;
        oq_push = 1'b1;
      end
      default: begin
        clearing = 1'b0;
      end
    endcase
  end

  // way match and lowest free way
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    for (int w = cfct_pkg::WAYS - 1; w >= 0; w--) begin
      if (rd_row_r[w].vld && rd_row_r[w].addr == item_r.ip &&
          rd_row_r[w].port == item_r.port) begin
        hit     = 1'b1;
        hit_way = cfct_pkg::WAY_BITS'(w);
      end
      if (!rd_row_r[w].vld) begin
        free     = 1'b1;
        free_way = cfct_pkg::WAY_BITS'(w);
      end
    end
  end

  always_comb begin
    sel_way    = hit ? hit_way : free_way;
    cur_cnt    = hit ? rd_row_r[hit_way].cnt : '0;
    new_cnt    = (cur_cnt == cfct_pkg::CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
    upd_row    = rd_row_r;
    res.count  = '0;
    res.status = cfct_pkg::ST_FULL;
    if (item_r.op == cfct_pkg::OP_CLOSE) begin
      if (hit) begin
        upd_row[hit_way].vld = 1'b0;
        res.status           = cfct_pkg::ST_REMOVED;
      end else begin
        res.status = cfct_pkg::ST_UNKNOWN;
      end
    end else if (hit || free) begin
      upd_row[sel_way].vld  = 1'b1;
      upd_row[sel_way].addr = item_r.ip;
      upd_row[sel_way].port = item_r.port;
      upd_row[sel_way].cnt  = new_cnt;
      res.count             = 32'(new_cnt);
      res.status            = cfct_pkg::ST_COUNTED;
    end
  end

  // row memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (q_pop) begin
      rd_row_r <= mem[q_item.bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
  end

  // result queue
  assign oq_pop     = out_pop && !out_empty;
  assign out_empty  = (oq_cnt_r == '0);
  assign out_count  = oq_r[oq_rd_r].count;
  assign out_status = oq_r[oq_rd_r].status;

  always_comb begin
    oq_wr_nxt  = oq_wr_r;
    oq_rd_nxt  = oq_rd_r;
    oq_cnt_nxt = oq_cnt_r;
    if (oq_push) begin
      oq_wr_nxt = (oq_wr_r == cfct_pkg::OQ_PTR_BITS'(cfct_pkg::OQ_DEPTH - 1)) ?
                  '0 : oq_wr_r + 1'b1;
    end
    if (oq_pop) begin
      oq_rd_nxt = (oq_rd_r == cfct_pkg::OQ_PTR_BITS'(cfct_pkg::OQ_DEPTH - 1)) ?
                  '0 : oq_rd_r + 1'b1;
    end
    if (oq_push && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + 1'b1;
    end else if (!oq_push && oq_pop) begin
      oq_cnt_nxt = oq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cfct_pkg::BS_CLEAR;
      clr_cnt_r <= '0;
      oq_wr_r   <= '0;
      oq_rd_r   <= '0;
      oq_cnt_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      oq_wr_r   <= oq_wr_nxt;
      oq_rd_r   <= oq_rd_nxt;
      oq_cnt_r  <= oq_cnt_nxt;
    end
  end

endmodule

[bench/tb_client_flow_counter_table_core.sv]
// testbench for client_flow_counter_table_core: directed and random count/close
// requests against an in-bench flow table predictor, with random push/pop idling
// depends on cfct_pkg and client_flow_counter_table_core
`timescale 1ns / 1ps

module tb_client_flow_counter_table_core;

  localparam int ENTRIES    = cfct_pkg::BUCKETS * cfct_pkg::WAYS;
  localparam int POOL_KEYS  = 24;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic        op;
    logic [31:0] ip;
    logic [15:0] port;
  } flow_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_op = 1'b0;
  logic [31:0] in_src_ip = '0;
  logic [15:0] in_src_port = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [31:0] out_count;
  logic [1:0]  out_status;

  flow_req_t      pending_reqs[$];
  cfct_pkg::res_t expected_results[$];

  logic                            flow_vld  [ENTRIES];
  logic [31:0]                     flow_addr [ENTRIES];
  logic [15:0]                     flow_port [ENTRIES];
  logic [cfct_pkg::COUNT_BITS-1:0] flow_cnt  [ENTRIES];

  int   errors = 0;
  int   results_seen = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  int   idle_cycles = 0;
  logic offer_next;
  logic pop_next;
  logic tail_phase = 1'b0;

  client_flow_counter_table_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_op      (in_op),
    .in_src_ip  (in_src_ip),
    .in_src_port(in_src_port),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_count  (out_count),
    .out_status (out_status)
  );

  always #4 clk = ~clk;

  function automatic cfct_pkg::res_t predict_flow_event(flow_req_t r);
    int unsigned    base;
    int             hit;
    int             free_slot;
    cfct_pkg::res_t res;
    base = ((r.ip ^ {16'd0, r.port}) % cfct_pkg::BUCKETS) * cfct_pkg::WAYS;
    hit = -1;
    free_slot = -1;
    for (int w = 0; w < cfct_pkg::WAYS; w++) begin
      if (flow_vld[base + w] && flow_addr[base + w] == r.ip &&
          flow_port[base + w] == r.port && hit < 0)
        hit = base + w;
      if (!flow_vld[base + w] && free_slot < 0)
        free_slot = base + w;
    end
    res.count = '0;
    if (r.op == cfct_pkg::OP_CLOSE) begin
      if (hit >= 0) begin
        flow_vld[hit] = 1'b0;
        res.status = cfct_pkg::ST_REMOVED;
      end else begin
        res.status = cfct_pkg::ST_UNKNOWN;
      end
    end else begin
      if (hit < 0 && free_slot >= 0) begin
        hit = free_slot;
        flow_vld[hit] = 1'b1;
        flow_addr[hit] = r.ip;
        flow_port[hit] = r.port;
        flow_cnt[hit] = '0;
      end
      if (hit >= 0) begin
        if (flow_cnt[hit] != cfct_pkg::CNT_MAX)
          flow_cnt[hit] = flow_cnt[hit] + 1'b1;
        res.count = 32'(flow_cnt[hit]);
        res.status = cfct_pkg::ST_COUNTED;
      end else begin
        res.status = cfct_pkg::ST_FULL;
      end
    end
    return res;
  endfunction

  // random key whose address xor port lands in the given bucket
  function automatic flow_req_t key_in_bucket(int unsigned bkt);
    flow_req_t r;
    r.op = cfct_pkg::OP_COUNT;
    r.ip = $urandom;
    r.port = 16'($urandom_range(0, 65535));
    r.port[cfct_pkg::BKT_BITS-1:0] = r.ip[cfct_pkg::BKT_BITS-1:0] ^
                                     bkt[cfct_pkg::BKT_BITS-1:0];
    return r;
  endfunction

  task automatic add_req(logic op, logic [31:0] ip, logic [15:0] port);
    flow_req_t r;
    r.op = op;
    r.ip = ip;
    r.port = port;
    pending_reqs.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at %0t: got %0d expected %0d", what, $realtime, got, want);
    errors++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      offer_next = in_push;
      if (in_push && !in_full) begin
        expected_results.push_back(predict_flow_event(pending_reqs.pop_front()));
        offer_next = 1'b0;
      end
      if (!offer_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0) begin
          if (!tail_phase && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 13) - 1;
          end else begin
            offer_next = 1'b1;
            in_op <= pending_reqs[0].op;
            in_src_ip <= pending_reqs[0].ip;
            in_src_port <= pending_reqs[0].port;
          end
        end
      end
      in_push <= offer_next;
      tail_phase <= (pending_reqs.size() < 100);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request waiting", out_count, 32'd0);
        end else begin
          if (out_count !== expected_results[0].count)
            report_mismatch("count", out_count, expected_results[0].count);
          if (out_status !== expected_results[0].status)
            report_mismatch("status", 32'(out_status),
                            32'(expected_results[0].status));
          void'(expected_results.pop_front());
        end
        // long hold so the request side backs up
        if (results_seen == 40 || results_seen == 450)
          hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop_next = 1'b0;
      end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        pop_next = 1'b0;
      end else begin
        pop_next = 1'b1;
      end
      out_pop <= pop_next;
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    flow_req_t   bkt_keys [5];
    flow_req_t   key_pool [POOL_KEYS];
    flow_req_t   req;
    int unsigned bkt;
    int          pick;

    for (int i = 0; i < ENTRIES; i++)
      flow_vld[i] = 1'b0;

    // directed requests
    add_req(cfct_pkg::OP_COUNT, 32'h0000_0000, 16'h0000);
    add_req(cfct_pkg::OP_COUNT, 32'h0000_0000, 16'h0000);
    add_req(cfct_pkg::OP_CLOSE, 32'h0000_0000, 16'h0000);
    add_req(cfct_pkg::OP_CLOSE, 32'h0000_0000, 16'h0000);
    add_req(cfct_pkg::OP_COUNT, 32'hFFFF_FFFF, 16'hFFFF);
    add_req(cfct_pkg::OP_COUNT, 32'h0000_0000, 16'h0000);
    for (int i = 0; i < 5; i++)
      bkt_keys[i] = key_in_bucket(7);
    for (int i = 0; i < 5; i++)
      add_req(cfct_pkg::OP_COUNT, bkt_keys[i].ip, bkt_keys[i].port);
    add_req(cfct_pkg::OP_CLOSE, bkt_keys[2].ip, bkt_keys[2].port);
    add_req(cfct_pkg::OP_COUNT, bkt_keys[4].ip, bkt_keys[4].port);
    add_req(cfct_pkg::OP_COUNT, bkt_keys[1].ip, bkt_keys[1].port);
    add_req(cfct_pkg::OP_CLOSE, bkt_keys[4].ip, bkt_keys[4].port);
    add_req(cfct_pkg::OP_COUNT, bkt_keys[4].ip, bkt_keys[4].port);
    add_req(cfct_pkg::OP_CLOSE, 32'hFFFF_FFFF, 16'hFFFF);
    add_req(cfct_pkg::OP_COUNT, 32'h8000_0000, 16'h8000);
    add_req(cfct_pkg::OP_CLOSE, $urandom, 16'($urandom_range(0, 65535)));
    add_req(cfct_pkg::OP_COUNT, 32'hFFFF_FFFF, 16'h0000);

    // random rounds over a small key pool crowding a few buckets
    for (int rnd = 0; rnd < 6; rnd++) begin
      for (int k = 0; k < POOL_KEYS; k++) begin
        if (k % 6 == 0)
          bkt = $urandom_range(0, cfct_pkg::BUCKETS - 1);
        key_pool[k] = key_in_bucket(bkt);
      end
      for (int n = 0; n < 147; n++) begin
        pick = $urandom_range(0, 99);
        req = key_pool[$urandom_range(0, POOL_KEYS - 1)];
        if (pick < 70) begin
          req.op = cfct_pkg::OP_COUNT;
        end else if (pick < 90) begin
          req.op = cfct_pkg::OP_CLOSE;
        end else begin
          req.op = 1'($urandom_range(0, 1));
          req.ip = $urandom;
          req.port = 16'($urandom_range(0, 65535));
        end
        pending_reqs.push_back(req);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || expected_results.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);

    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[files.f]
hdl/cfct_pkg.sv
hdl/cfct_front.sv
hdl/cfct_back.sv
hdl/client_flow_counter_table_core.sv
bench/tb_client_flow_counter_table_core.sv
